/* rtl/rgb_to_hsv_converter_macros.svh */
// assertion macros used by the checker file
`ifndef RGB_TO_HSV_CONVERTER_MACROS_SVH
`define RGB_TO_HSV_CONVERTER_MACROS_SVH

// same-cycle implication, sampled on the rising clock, off during reset
`define RTV_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RTV_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/rtv_pkg.sv */
// shared constants, types and the work-word layout for the rgb to hsv converter
package rtv_pkg;

  localparam int CHANNEL_BITS = 8;
  localparam int FRAC_BITS    = 12;
  localparam int SAT_BITS     = FRAC_BITS + 1;
  localparam int NUM_BITS     = CHANNEL_BITS + 3;
  localparam int FIFO_DEPTH   = 2;
  localparam int FIFO_PTR_W   = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W   = $clog2(FIFO_DEPTH + 1);
  localparam int DIV_STAGES   = FRAC_BITS + 1;

  typedef logic [CHANNEL_BITS-1:0] chan_t;
  typedef logic [NUM_BITS-1:0]     num_t;

  typedef enum logic [2:0] {
    SEC_RY = 3'd0,
    SEC_YG = 3'd1,
    SEC_GC = 3'd2,
    SEC_CB = 3'd3,
    SEC_BM = 3'd4,
    SEC_MR = 3'd5
  } sector_e;

  // word passed from the classifier to the divider pipeline
  typedef struct packed {
    chan_t hi;
    chan_t d;
    num_t  num;
    num_t  den;
    logic  hue_zero;
    logic  sat_zero;
  } job_t;

endpackage

/* rtl/rtv_if.sv */
// valid/ready channel interfaces for pixels in and hsv results out
interface rtv_pix_if;
  logic                              valid;
  logic                              ready;
  logic [rtv_pkg::CHANNEL_BITS-1:0]  red;
  logic [rtv_pkg::CHANNEL_BITS-1:0]  green;
  logic [rtv_pkg::CHANNEL_BITS-1:0]  blue;
  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

interface rtv_hsv_if;
  logic                              valid;
  logic                              ready;
  logic [rtv_pkg::FRAC_BITS-1:0]     hue;
  logic [rtv_pkg::SAT_BITS-1:0]      saturation;
  logic [rtv_pkg::CHANNEL_BITS-1:0]  value;
  modport source (output valid, hue, saturation, value, input ready);
  modport sink   (input valid, hue, saturation, value, output ready);
endinterface

/* rtl/rtv_front.sv */
// front end: accepts pixels, finds max/min, sector and divider operands
module rtv_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  rtv_pkg::chan_t      red_i,
  input  rtv_pkg::chan_t      green_i,
  input  rtv_pkg::chan_t      blue_i,
  output logic                job_valid_o,
  input  logic                job_ready_i,
  output rtv_pkg::job_t       job_o
);

  rtv_pkg::chan_t   hi, lo, d, share;
  rtv_pkg::sector_e sec;
  rtv_pkg::job_t    job_d, job_q;
  logic             vld_q;

  always_comb begin
    hi = red_i;
    if (green_i > hi) hi = green_i;
    if (blue_i > hi) hi = blue_i;
    lo = red_i;
    if (green_i < lo) lo = green_i;
    if (blue_i < lo) lo = blue_i;
    d = hi - lo;
    if (red_i == hi && blue_i == lo) begin
      sec = rtv_pkg::SEC_RY; share = green_i - lo;
    end else if (green_i == hi && blue_i == lo) begin
      sec = rtv_pkg::SEC_YG; share = hi - red_i;
    end else if (green_i == hi) begin
      sec = rtv_pkg::SEC_GC; share = blue_i - lo;
    end else if (blue_i == hi && red_i == lo) begin
      sec = rtv_pkg::SEC_CB; share = hi - green_i;
    end else if (blue_i == hi) begin
      sec = rtv_pkg::SEC_BM; share = red_i - lo;
    end else begin
      sec = rtv_pkg::SEC_MR; share = hi - blue_i;
    end
    job_d.hi       = hi;
    job_d.d        = d;
    job_d.num      = rtv_pkg::NUM_BITS'(rtv_pkg::num_t'(sec) * rtv_pkg::num_t'(d))
                   + rtv_pkg::num_t'(share);
    job_d.den      = rtv_pkg::NUM_BITS'(rtv_pkg::num_t'(d) * rtv_pkg::num_t'(3'd6));
    job_d.hue_zero = (d == '0);
    job_d.sat_zero = (hi == '0);
  end

  assign in_ready_o  = ~vld_q | job_ready_i;
  assign job_valid_o = vld_q;
  assign job_o       = job_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_ready_o) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      job_q <= job_d;
    end
  end

endmodule

/* rtl/rtv_fifo.sv */
// short queue between classifier and divider
module rtv_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  rtv_pkg::job_t push_data_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output rtv_pkg::job_t pop_data_o
);

  rtv_pkg::job_t                     mem_q [rtv_pkg::FIFO_DEPTH];
  logic [rtv_pkg::FIFO_PTR_W-1:0]    wr_q, rd_q;
  logic [rtv_pkg::FIFO_CNT_W-1:0]    cnt_q;
  logic                              push, pop;

  assign push_ready_o = (cnt_q != rtv_pkg::FIFO_CNT_W'(rtv_pkg::FIFO_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_q];
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= (wr_q == rtv_pkg::FIFO_PTR_W'(rtv_pkg::FIFO_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      if (pop)  rd_q <= (rd_q == rtv_pkg::FIFO_PTR_W'(rtv_pkg::FIFO_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      if (push && !pop) cnt_q <= cnt_q + 1'b1;
      else if (pop && !push) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= push_data_i;
  end

endmodule

/* rtl/rtv_back.sv */
// back end: pipelined restoring dividers, one quotient bit per stage
module rtv_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              job_valid_i,
  output logic                              job_ready_o,
  input  rtv_pkg::job_t                     job_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [rtv_pkg::FRAC_BITS-1:0]     hue_o,
  output logic [rtv_pkg::SAT_BITS-1:0]      saturation_o,
  output rtv_pkg::chan_t                    value_o
);

  localparam int NS = rtv_pkg::DIV_STAGES;
  localparam int NW = rtv_pkg::NUM_BITS;
  localparam int CW = rtv_pkg::CHANNEL_BITS;

  logic                             vld_q  [NS];
  rtv_pkg::num_t                    hrem_q [NS];
  rtv_pkg::chan_t                   srem_q [NS];
  logic [rtv_pkg::FRAC_BITS-1:0]    hq_q   [NS];
  logic [rtv_pkg::SAT_BITS-1:0]     sq_q   [NS];
  rtv_pkg::chan_t                   hi_q   [NS];
  rtv_pkg::num_t                    den_q  [NS];
  logic                             hz_q   [NS];
  logic                             sz_q   [NS];
  logic                             en;
  logic                             s_top;

  // whole pipeline moves unless the result register is held
  assign en          = ~vld_q[NS-1] | out_ready_i;
  assign job_ready_o = en;
  assign s_top       = (job_i.d >= job_i.hi);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= job_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hrem_q[0] <= job_i.num;
      srem_q[0] <= s_top ? job_i.d - job_i.hi : job_i.d;
      hq_q[0]   <= '0;
      sq_q[0]   <= rtv_pkg::SAT_BITS'(s_top);
      hi_q[0]   <= job_i.hi;
      den_q[0]  <= job_i.den;
      hz_q[0]   <= job_i.hue_zero;
      sz_q[0]   <= job_i.sat_zero;
    end
  end

  for (genvar k = 1; k < NS; k++) begin : g_stage
    logic [NW:0] ht;
    logic [CW:0] st;
    logic        hbit, sbit;

    always_comb begin
      ht   = {hrem_q[k-1], 1'b0};
      st   = {srem_q[k-1], 1'b0};
      hbit = (ht >= {1'b0, den_q[k-1]});
      sbit = (st >= {1'b0, hi_q[k-1]});
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en) begin
        vld_q[k] <= vld_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        hrem_q[k] <= hbit ? NW'(ht - {1'b0, den_q[k-1]}) : NW'(ht);
        srem_q[k] <= sbit ? CW'(st - {1'b0, hi_q[k-1]}) : CW'(st);
        hq_q[k]   <= {hq_q[k-1][rtv_pkg::FRAC_BITS-2:0], hbit};
        sq_q[k]   <= {sq_q[k-1][rtv_pkg::SAT_BITS-2:0], sbit};
        hi_q[k]   <= hi_q[k-1];
        den_q[k]  <= den_q[k-1];
        hz_q[k]   <= hz_q[k-1];
        sz_q[k]   <= sz_q[k-1];
      end
    end
  end

  assign out_valid_o  = vld_q[NS-1];
  assign hue_o        = hz_q[NS-1] ? '0 : hq_q[NS-1];
  assign saturation_o = sz_q[NS-1] ? '0 : sq_q[NS-1];
  assign value_o      = hi_q[NS-1];

endmodule

/* rtl/rgb_to_hsv_converter.sv */
// rgb to hsv converter: one pixel word in, one hsv word out, fixed point
// throughput: one word per cycle while the output is not held, set by the fully pipelined dividers
// path from accept to result: input register, queue, then FRAC_BITS+1 divider
// stages, one quotient bit each
// reset: asynchronous active low, empties all stages and the queue
module rgb_to_hsv_converter (
  input  logic       clk_i,
  input  logic       rst_ni,
  rtv_pix_if.sink    pix_i,
  rtv_hsv_if.source  hsv_o
);

  logic          fr_valid, fr_ready, bk_valid, bk_ready;
  rtv_pkg::job_t fr_job, bk_job;

  rtv_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pix_i.valid),
    .in_ready_o  (pix_i.ready),
    .red_i       (pix_i.red),
    .green_i     (pix_i.green),
    .blue_i      (pix_i.blue),
    .job_valid_o (fr_valid),
    .job_ready_i (fr_ready),
    .job_o       (fr_job)
  );

  rtv_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_data_i  (fr_job),
    .pop_valid_o  (bk_valid),
    .pop_ready_i  (bk_ready),
    .pop_data_o   (bk_job)
  );

  rtv_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_valid_i  (bk_valid),
    .job_ready_o  (bk_ready),
    .job_i        (bk_job),
    .out_valid_o  (hsv_o.valid),
    .out_ready_i  (hsv_o.ready),
    .hue_o        (hsv_o.hue),
    .saturation_o (hsv_o.saturation),
    .value_o      (hsv_o.value)
  );

endmodule

/* rtl/rtv_checker.sv */
// port-level checks on the converter output, bound to the top level
`include "rgb_to_hsv_converter_macros.svh"

module rtv_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            out_valid_i,
  input logic                            out_ready_i,
  input logic [rtv_pkg::FRAC_BITS-1:0]   hue_i,
  input logic [rtv_pkg::SAT_BITS-1:0]    saturation_i,
  input rtv_pkg::chan_t                  value_i
);

  `RTV_ASSERT_NXT(a_hold_valid, out_valid_i && !out_ready_i, out_valid_i, "word dropped while stalled")
  `RTV_ASSERT_NXT(a_hold_data, out_valid_i && !out_ready_i, $stable(hue_i) && $stable(saturation_i) && $stable(value_i), "word changed while stalled")
  `RTV_ASSERT_IMP(a_sat_range, out_valid_i, saturation_i <= (rtv_pkg::SAT_BITS'(1) << rtv_pkg::FRAC_BITS), "saturation above one")
  `RTV_ASSERT_IMP(a_black, out_valid_i && value_i == '0, hue_i == '0 && saturation_i == '0, "black gives nonzero hue or saturation")

endmodule

bind rgb_to_hsv_converter rtv_checker u_rtv_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (hsv_o.valid),
  .out_ready_i  (hsv_o.ready),
  .hue_i        (hsv_o.hue),
  .saturation_i (hsv_o.saturation),
  .value_i      (hsv_o.value)
);
